### hw/rtl/hkts_pkg.sv
// ============================================================================
// hkts_pkg
// Shared types and constants for the hashed key table search core.
// ============================================================================
package hkts_pkg;

    localparam int MAX_ENTRIES_DEF     = 4096;
    localparam int KEY_STORE_BYTES_DEF = 65536;
    localparam int MAX_KEY_LEN_DEF     = 64;
    localparam int BUCKET_SHIFT_DEF    = 16;
    localparam int BUCKET_DEPTH        = 65536;
    localparam int BUCKET_AW           = 16;

    localparam logic [2:0] CMD_LOAD_ENTRY  = 3'd0;
    localparam logic [2:0] CMD_LOAD_KEY    = 3'd1;
    localparam logic [2:0] CMD_LOAD_BUCKET = 3'd2;
    localparam logic [2:0] CMD_LOAD_NEEDLE = 3'd3;
    localparam logic [2:0] CMD_LOOKUP      = 3'd4;

    localparam logic CFG_USE_BUCKETS = 1'b0;
    localparam logic CFG_ENTRY_COUNT = 1'b1;

    typedef struct packed {
        logic [2:0]  command;
        logic [15:0] address;
        logic [31:0] hash_value;
        logic [15:0] key_offset;
        logic [6:0]  key_length;
        logic [23:0] label_start;
        logic [15:0] label_length;
        logic [11:0] bucket_start;
        logic [12:0] bucket_count;
        logic [7:0]  byte_value;
    } t_in_item;

    typedef struct packed {
        logic        found;
        logic [23:0] label_offset;
        logic [15:0] label_count;
    } t_out_item;

    // Entry record held in the entry memory.
    typedef struct packed {
        logic [31:0] hash;
        logic [15:0] key_off;
        logic [6:0]  key_len;
        logic [23:0] lbl_start;
        logic [15:0] lbl_count;
    } t_entry;

endpackage

### hw/rtl/hkts_entry_mem.sv
// ============================================================================
// hkts_entry_mem
// Entry table memory: hash, key section and label section per entry.
// ============================================================================
module hkts_entry_mem #(
    parameter int MAX_ENTRIES = hkts_pkg::MAX_ENTRIES_DEF,
    parameter int AW          = $clog2(MAX_ENTRIES)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  hkts_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output hkts_pkg::t_entry o_rdata
);
    hkts_pkg::t_entry r_mem [MAX_ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/hkts_byte_mem.sv
// ============================================================================
// hkts_byte_mem
// Byte-wide synchronous memory for key bytes and needle bytes.
// ============================================================================
module hkts_byte_mem #(
    parameter int DEPTH = hkts_pkg::KEY_STORE_BYTES_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);
    logic [7:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### hw/rtl/hashed_key_table_search_core.sv
// ============================================================================
// hashed_key_table_search_core
// Binary search over a sorted, hashed key table held in on-chip memories.
// ============================================================================
// Load commands (entry, key byte, bucket, needle byte) are taken one per cycle
// while the block is idle. A lookup reads the bucket memory (BKT) and then
// sets up the range (RANGE). It then runs one probe per halving of the range.
// Each probe reads the entry memory (PROBE, EWAIT) and compares the hash
// (HASH). On a hash match it then streams up to min(needle, key) bytes through
// the key byte memory and the needle memory, reading and then comparing each
// byte (BWAIT, BYTE). A lookup runs up to 13 probes for a full 4096-entry
// range. The byte-serial compare loop sets the rate. The result moves to an
// output register and the block goes idle, ready for further transactions. A
// following lookup holds its own result until the earlier one has been taken.
// No clearing pass: stores are undefined until written.
module hashed_key_table_search_core #(
    parameter int MAX_ENTRIES     = hkts_pkg::MAX_ENTRIES_DEF,
    parameter int KEY_STORE_BYTES = hkts_pkg::KEY_STORE_BYTES_DEF,
    parameter int MAX_KEY_LEN     = hkts_pkg::MAX_KEY_LEN_DEF,
    parameter int BUCKET_SHIFT    = hkts_pkg::BUCKET_SHIFT_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  hkts_pkg::t_in_item  i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output hkts_pkg::t_out_item o_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_index,
    input  logic [12:0]         i_cfg_data
);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int KAW = $clog2(KEY_STORE_BYTES);
    localparam int NAW = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
    localparam int CW  = EAW + 2;  // count/range width, holds MAX_ENTRIES
    localparam int LW  = $clog2(MAX_KEY_LEN + 1) + 1;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_BKT    = 4'd1;
    localparam logic [3:0] ST_RANGE  = 4'd2;
    localparam logic [3:0] ST_PROBE  = 4'd3;
    localparam logic [3:0] ST_EWAIT  = 4'd4;
    localparam logic [3:0] ST_HASH   = 4'd5;
    localparam logic [3:0] ST_BWAIT  = 4'd6;
    localparam logic [3:0] ST_BYTE   = 4'd7;
    localparam logic [3:0] ST_OUT    = 4'd8;

    logic [3:0]          r_state, n_state;
    logic                r_use_buckets;
    logic [12:0]         r_entry_count;
    hkts_pkg::t_in_item  r_item;
    logic [CW-1:0]       r_lo, r_hi;  // hi kept exclusive: range [lo, hi)
    logic [CW-1:0]       r_base;
    logic [CW-1:0]       r_mid;
    logic [CW-1:0]       mid_abs;
    logic [LW-1:0]       r_nlen, r_pos, r_n;
    hkts_pkg::t_entry    r_ent;
    logic                r_out_valid;
    hkts_pkg::t_out_item r_out;
    hkts_pkg::t_out_item r_res;  // result being built by the running search

    // Compare outcome helpers.
    logic c_found, c_gt, c_done;

    // Bucket memory: start in low 12 bits, count in upper 13.
    logic [24:0] r_bkt_mem [hkts_pkg::BUCKET_DEPTH];
    logic [24:0] r_bkt_rd;

    logic             ent_we;
    hkts_pkg::t_entry ent_wd, ent_rd;
    logic [EAW-1:0]   ent_ra;
    logic             key_we, ndl_we;
    logic [KAW-1:0]   key_ra;
    logic [NAW-1:0]   ndl_ra;
    logic [7:0]       key_rd, ndl_rd;
    logic [31:0]      hash_sh;
    logic [hkts_pkg::BUCKET_AW-1:0] bkt_ra;

    logic accept_in;
    assign accept_in = i_valid && o_ready;
    assign o_ready   = (r_state == ST_IDLE);
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_use_buckets <= 1'b1;
            r_entry_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                hkts_pkg::CFG_USE_BUCKETS: r_use_buckets <= i_cfg_data[0];
                hkts_pkg::CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Bucket memory write/read; read from the held lookup hash.
    assign hash_sh = r_item.hash_value >> BUCKET_SHIFT;
    assign bkt_ra  = hash_sh[hkts_pkg::BUCKET_AW-1:0];
    always_ff @(posedge i_clk) begin
        if (accept_in && i_data.command == hkts_pkg::CMD_LOAD_BUCKET) begin
            r_bkt_mem[i_data.address] <= {i_data.bucket_count, i_data.bucket_start};
        end
        r_bkt_rd <= r_bkt_mem[bkt_ra];
    end

    // Entry write; read address follows the probe midpoint so data lands in EWAIT.
    assign ent_we = accept_in && i_data.command == hkts_pkg::CMD_LOAD_ENTRY
                    && ({16'd0, i_data.address} < 32'(MAX_ENTRIES));
    assign ent_wd = '{hash: i_data.hash_value, key_off: i_data.key_offset,
                      key_len: i_data.key_length, lbl_start: i_data.label_start,
                      lbl_count: i_data.label_length};
    assign ent_ra = mid_abs[EAW-1:0];

    hkts_entry_mem #(.MAX_ENTRIES(MAX_ENTRIES), .AW(EAW)) u_entry (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(i_data.address[EAW-1:0]),
        .i_wdata(ent_wd), .i_raddr(ent_ra), .o_rdata(ent_rd)
    );

    assign key_we = accept_in && i_data.command == hkts_pkg::CMD_LOAD_KEY
                    && ({16'd0, i_data.address} < 32'(KEY_STORE_BYTES));
    logic [31:0] key_addr_sum;
    assign key_addr_sum = 32'(r_ent.key_off) + 32'(r_pos);
    assign key_ra = key_addr_sum[KAW-1:0];

    logic [KAW-1:0] key_wa;
    logic [31:0]    key_wa_ext;
    assign key_wa_ext = 32'(i_data.address);
    assign key_wa     = key_wa_ext[KAW-1:0];

    hkts_byte_mem #(.DEPTH(KEY_STORE_BYTES), .AW(KAW)) u_key (
        .i_clk(i_clk), .i_we(key_we), .i_waddr(key_wa),
        .i_wdata(i_data.byte_value), .i_raddr(key_ra), .o_rdata(key_rd)
    );

    assign ndl_we = accept_in && i_data.command == hkts_pkg::CMD_LOAD_NEEDLE
                    && ({16'd0, i_data.address} < 32'(MAX_KEY_LEN));
    logic [31:0] ndl_pos_ext, ndl_wa_ext;
    assign ndl_pos_ext = 32'(r_pos);
    assign ndl_ra      = ndl_pos_ext[NAW-1:0];
    assign ndl_wa_ext  = 32'(i_data.address);

    hkts_byte_mem #(.DEPTH(MAX_KEY_LEN), .AW(NAW)) u_needle (
        .i_clk(i_clk), .i_we(ndl_we), .i_waddr(ndl_wa_ext[NAW-1:0]),
        .i_wdata(i_data.byte_value), .i_raddr(ndl_ra), .o_rdata(ndl_rd)
    );

    // Range setup from bucket or table size; clip to MAX_ENTRIES.
    logic [CW-1:0] rng_base, rng_cnt, rng_room, rng_clip;
    always_comb begin
        if (r_use_buckets) begin
            rng_base = CW'(r_bkt_rd[11:0]);
            rng_cnt  = CW'(r_bkt_rd[24:12]);
        end else begin
            rng_base = '0;
            rng_cnt  = CW'(r_entry_count);
        end
        rng_room = CW'(MAX_ENTRIES) - rng_base;
        if (rng_base >= CW'(MAX_ENTRIES)) rng_clip = '0;
        else if (rng_cnt > rng_room)      rng_clip = rng_room;
        else                              rng_clip = rng_cnt;
    end

    logic [CW-1:0] mid_off;
    logic [CW:0]   lohi_sum;
    assign lohi_sum = {1'b0, r_lo} + {1'b0, r_hi} - 1'b1;
    assign mid_off  = lohi_sum[CW:1];
    assign mid_abs  = r_base + mid_off;

    logic [LW-1:0] elen_ext;
    assign elen_ext = LW'(r_ent.key_len);

    // Control sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (accept_in && i_data.command == hkts_pkg::CMD_LOOKUP)
                          n_state = ST_BKT;
            ST_BKT:   n_state = ST_RANGE;
            ST_RANGE: n_state = ST_PROBE;
            ST_PROBE: n_state = (r_lo < r_hi) ? ST_EWAIT : ST_OUT;
            ST_EWAIT: n_state = ST_HASH;
            ST_HASH: begin
                if (r_ent.hash != r_item.hash_value) n_state = ST_PROBE;
                else if (r_n != '0)                  n_state = ST_BWAIT;
                else if (r_nlen == elen_ext)         n_state = ST_OUT;
                else                                 n_state = ST_PROBE;
            end
            ST_BWAIT: n_state = ST_BYTE;
            ST_BYTE: begin
                if (!c_done)      n_state = ST_BWAIT;
                else if (c_found) n_state = ST_OUT;
                else              n_state = ST_PROBE;
            end
            ST_OUT:   n_state = (!r_out_valid || i_ready) ? ST_IDLE : ST_OUT;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && (!r_out_valid || i_ready)) r_out_valid <= 1'b1;
            else if (r_out_valid && i_ready)                     r_out_valid <= 1'b0;
        end
    end

    // Byte compare step: decide after each byte or at the end of min length.
    always_comb begin
        c_done  = 1'b0;
        c_found = 1'b0;
        c_gt    = 1'b0;
        if (ndl_rd != key_rd) begin
            c_done = 1'b1;
            c_gt   = ndl_rd > key_rd;
        end else if (r_pos + 1'b1 == r_n) begin
            c_done  = 1'b1;
            c_found = (r_nlen == elen_ext);
            c_gt    = r_nlen > elen_ext;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (accept_in) begin
                    r_item <= i_data;
                    r_nlen <= (32'(i_data.key_length) > 32'(MAX_KEY_LEN))
                              ? LW'(MAX_KEY_LEN) : LW'(i_data.key_length);
                    r_res  <= '0;
                end
            end
            ST_RANGE: begin
                r_base <= rng_base;
                r_lo   <= '0;
                r_hi   <= rng_clip;
            end
            ST_PROBE: begin
                r_mid <= mid_abs;
                r_pos <= '0;
            end
            ST_HASH: begin
                if (r_ent.hash != r_item.hash_value) begin
                    if (r_item.hash_value > r_ent.hash) r_lo <= r_mid - r_base + 1'b1;
                    else                                r_hi <= r_mid - r_base;
                end else if (r_n == '0) begin
                    if (r_nlen == elen_ext) begin
                        r_res <= '{found: 1'b1, label_offset: r_ent.lbl_start,
                                   label_count: r_ent.lbl_count};
                    end else if (r_nlen > elen_ext) r_lo <= r_mid - r_base + 1'b1;
                    else                            r_hi <= r_mid - r_base;
                end
            end
            ST_BYTE: begin
                if (c_done) begin
                    if (c_found) begin
                        r_res <= '{found: 1'b1, label_offset: r_ent.lbl_start,
                                   label_count: r_ent.lbl_count};
                    end else if (c_gt) r_lo <= r_mid - r_base + 1'b1;
                    else               r_hi <= r_mid - r_base;
                end else begin
                    r_pos <= r_pos + 1'b1;
                end
            end
            ST_OUT: begin
                // hand the result over only once the output register is free
                if (!r_out_valid || i_ready) r_out <= r_res;
            end
            default: ;
        endcase
        if (r_state == ST_EWAIT) begin
            r_ent <= ent_rd;
            r_n   <= (r_nlen < LW'(ent_rd.key_len)) ? r_nlen : LW'(ent_rd.key_len);
        end
    end

`ifndef SYNTHESIS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_range_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EWAIT |-> r_lo < r_hi) else $error("probe on empty range");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_data.found) |-> (o_data.label_offset == '0
        && o_data.label_count == '0)) else $error("miss with nonzero labels");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_BYTE |-> r_pos < r_n) else $error("byte index past length");
`endif
endmodule
